// ===== rtl/pbdo_pkg.sv =====
package pbdo_pkg;

  localparam int COORD_BITS = 20;
  localparam int MAX_BINS_X = 64;
  localparam int MAX_BINS_Y = 64;
  localparam int BX_W       = $clog2(MAX_BINS_X);
  localparam int BY_W       = $clog2(MAX_BINS_Y);
  localparam int NBINS      = MAX_BINS_X * MAX_BINS_Y;
  localparam int ADDR_W     = BX_W + BY_W;

  localparam int FREE_W  = 25;
  localparam int USE_W   = 32;
  localparam int AREA_W  = 48;
  localparam int TU_W    = 18;
  localparam int BIN_W   = 13;
  localparam int NB_W    = 7;
  localparam int CNT_W   = 13;
  localparam int EDGE_W  = COORD_BITS + 2;
  localparam int SPAN_W  = BIN_W;
  localparam int PROD_W  = 2 * BIN_W;
  localparam int FT_W    = FREE_W + TU_W;
  localparam int CROSS_W = USE_W + FREE_W;
  localparam int SUM_W   = 61;
  localparam int K_W     = PROD_W + TU_W;
  localparam int KLO_W   = K_W / 2;
  localparam int PP_W    = 32 + KLO_W;
  localparam int P_W     = SUM_W + K_W;
  localparam int DEN_W   = AREA_W + 9;
  localparam int RCT_W   = 2 * COORD_BITS;
  localparam int S_W     = 24;

  localparam int PEN_DIVISOR = 400;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [5:0] DIV_Q32 = 6'd32;
  localparam logic [5:0] DIV_Q24 = 6'd24;

  localparam logic [FREE_W-1:0] FREE_MAX = '1;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_FIXED   = 2'd1,
    OP_MOVABLE = 2'd2,
    OP_REPORT  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CORE_LEFT   = 3'd0,
    CFG_CORE_BOTTOM = 3'd1,
    CFG_CORE_RIGHT  = 3'd2,
    CFG_CORE_TOP    = 3'd3,
    CFG_BIN_WIDTH   = 3'd4,
    CFG_BIN_HEIGHT  = 3'd5,
    CFG_BINS_X      = 3'd6,
    CFG_BINS_Y      = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BIN_RD,
    ST_BIN_MUL,
    ST_BIN_WR,
    ST_FIN_MX,
    ST_MX_WAIT,
    ST_FIN_RT,
    ST_RT_WAIT,
    ST_PEN_P,
    ST_PEN_DIV,
    ST_PEN_WAIT,
    ST_PEN_SQ,
    ST_OUT
  } st_t;

  typedef struct packed {
    op_t                   kind;
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS:0]   x1;
    logic [COORD_BITS:0]   y1;
    logic [RCT_W-1:0]      area;
    logic                  outside;
    logic [TU_W-1:0]       tu;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [63:0] hi;
    logic [31:0] lo;
    logic [63:0] den;
    logic [5:0]  cnt;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/pbdo_if.sv =====
interface pbdo_in_if import pbdo_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            opcode;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [COORD_BITS-1:0] size_w;
  logic [COORD_BITS-1:0] size_h;
  logic                  outside_core;
  logic [TU_W-1:0]       target_util;

  modport source (output valid, opcode, pos_x, pos_y, size_w, size_h, outside_core,
                  target_util, input ready);
  modport sink (input valid, opcode, pos_x, pos_y, size_w, size_h, outside_core,
                target_util, output ready);
endinterface

interface pbdo_out_if import pbdo_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AREA_W-1:0] total_overflow;
  logic [CNT_W-1:0]  violation_count;
  logic [CNT_W-1:0]  nonzero_bins;
  logic [31:0]       max_util;
  logic [31:0]       overflow_ratio;
  logic [31:0]       penalty;

  modport source (output valid, total_overflow, violation_count, nonzero_bins, max_util,
                  overflow_ratio, penalty, input ready);
  modport sink (input valid, total_overflow, violation_count, nonzero_bins, max_util,
                overflow_ratio, penalty, output ready);
endinterface

// ===== rtl/pbdo_ram.sv =====
module pbdo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/pbdo_front.sv =====
module pbdo_front import pbdo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pbdo_in_if.sink   in_ch,
  output logic      push_valid,
  input  logic      push_ready,
  output cmd_t      push_data
);
  logic                  stage_v_r;
  logic [1:0]            op_r;
  logic [COORD_BITS-1:0] px_r, py_r, sw_r, sh_r;
  logic                  out_r;
  logic [TU_W-1:0]       tu_r;

  assign in_ch.ready = !stage_v_r || push_ready;
  assign push_valid  = stage_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      stage_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r  <= in_ch.opcode;
      px_r  <= in_ch.pos_x;
      py_r  <= in_ch.pos_y;
      sw_r  <= in_ch.size_w;
      sh_r  <= in_ch.size_h;
      out_r <= in_ch.outside_core;
      tu_r  <= in_ch.target_util;
    end
  end

  // classify and precompute rectangle corners and area
  always_comb begin
    push_data.kind    = op_t'(op_r);
    push_data.x0      = px_r;
    push_data.y0      = py_r;
    push_data.x1      = {1'b0, px_r} + {1'b0, sw_r};
    push_data.y1      = {1'b0, py_r} + {1'b0, sh_r};
    push_data.area    = {{COORD_BITS{1'b0}}, sw_r} * {{COORD_BITS{1'b0}}, sh_r};
    push_data.outside = out_r;
    push_data.tu      = tu_r;
  end
endmodule

// ===== rtl/pbdo_queue.sv =====
module pbdo_queue import pbdo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);
  cmd_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = ent_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop) rp_r <= !rp_r;
      if (do_push && !do_pop) cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= push_data;
  end
endmodule

// ===== rtl/pbdo_div.sv =====
module pbdo_div import pbdo_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic        run_r, done_r;
  logic [5:0]  cnt_r;
  logic [63:0] rem_r, den_r;
  logic [31:0] lo_r, q_r;
  logic [64:0] rem2;
  logic        ge;

  // one quotient bit per cycle, remainder kept below the divisor
  assign rem2 = {rem_r, lo_r[31]};
  assign ge   = (rem2 >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= req.cnt;
      end else if (run_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.hi;
      lo_r  <= req.lo;
      den_r <= req.den;
      q_r   <= 32'd0;
    end else if (run_r) begin
      rem_r <= ge ? 64'(rem2 - {1'b0, den_r}) : rem2[63:0];
      q_r   <= {q_r[30:0], ge};
      lo_r  <= {lo_r[30:0], 1'b0};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
endmodule

// ===== rtl/pbdo_back.sv =====
module pbdo_back import pbdo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  cmd_t                  pop_data,
  output div_req_t              div_req,
  input  div_rsp_t              div_rsp,
  pbdo_out_if.source            out_ch
);
  // configuration
  logic [COORD_BITS-1:0] core_left_r, core_bottom_r, core_right_r, core_top_r;
  logic [BIN_W-1:0]      bin_w_r, bin_h_r;
  logic [NB_W-1:0]       bins_x_r, bins_y_r;

  st_t state_r, state_nxt;
  cmd_t cmd_r;

  logic [BX_W-1:0]   i_r, xlast_r;
  logic [BY_W-1:0]   j_r, ylast_r;
  logic [EDGE_W-1:0] lx_r, ly_r;
  logic [SPAN_W-1:0] sx_r, sy_r;
  logic [PROD_W-1:0] prod_r;
  logic [USE_W-1:0]  u_r, ub_r;
  logic [FREE_W-1:0] f_r, fb_r;
  logic [FT_W-1:0]   ft_r;
  logic [CROSS_W-1:0] c1_r, c2_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  vio_r, nz_r;
  logic [AREA_W-1:0] mat_r;
  logic [31:0]       mx_r, rt_r, pen_r;
  logic [PROD_W-1:0] bwh_r;
  logic [K_W-1:0]    k_r;
  logic [DEN_W-1:0]  den_r;
  logic [PP_W-1:0]   pp_r;
  logic [1:0]        psel_r;
  logic [2:0]        pcnt_r;
  logic [P_W-1:0]    pacc_r;
  logic [S_W-1:0]    s_r;

  logic                  ores_v_r;
  logic [AREA_W-1:0]     o_to_r;
  logic [CNT_W-1:0]      o_vio_r, o_nz_r;
  logic [31:0]           o_mx_r, o_rt_r, o_pen_r;

  // ram ports
  logic [ADDR_W-1:0] addr;
  logic              free_we, use_we;
  logic [FREE_W-1:0] free_wdata, free_rdata;
  logic [USE_W-1:0]  use_wdata, use_rdata;

  // bin edges and overlap
  logic [EDGE_W-1:0] xe, xc, xr, ye, yc, yr, xlo, xhi, ylo, yhi;
  logic [SPAN_W-1:0] wx, wy, spx, spy;
  logic [NB_W-1:0]   nx, ny;
  logic              empty, last_bin, out_load;
  logic [47:0]       uq;
  logic [32:0]       usum;
  logic [31:0]       pa;
  logic [KLO_W-1:0]  pb;
  logic [P_W-1:0]    pshift;
  logic [AREA_W:0]   mat_sum;

  assign addr = {i_r, j_r};

  pbdo_ram #(.WIDTH(FREE_W), .DEPTH(NBINS)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(addr), .wdata(free_wdata),
    .raddr(addr), .rdata(free_rdata)
  );

  pbdo_ram #(.WIDTH(USE_W), .DEPTH(NBINS)) u_use_ram (
    .clk(clk), .we(use_we), .waddr(addr), .wdata(use_wdata),
    .raddr(addr), .rdata(use_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_left_r   <= '0;
      core_bottom_r <= '0;
      core_right_r  <= COORD_BITS'(4096);
      core_top_r    <= COORD_BITS'(4096);
      bin_w_r       <= BIN_W'(64);
      bin_h_r       <= BIN_W'(64);
      bins_x_r      <= NB_W'(64);
      bins_y_r      <= NB_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_CORE_LEFT:   core_left_r   <= cfg_wdata;
        CFG_CORE_BOTTOM: core_bottom_r <= cfg_wdata;
        CFG_CORE_RIGHT:  core_right_r  <= cfg_wdata;
        CFG_CORE_TOP:    core_top_r    <= cfg_wdata;
        CFG_BIN_WIDTH:   bin_w_r       <= cfg_wdata[BIN_W-1:0];
        CFG_BIN_HEIGHT:  bin_h_r       <= cfg_wdata[BIN_W-1:0];
        CFG_BINS_X:      bins_x_r      <= cfg_wdata[NB_W-1:0];
        CFG_BINS_Y:      bins_y_r      <= cfg_wdata[NB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nx    = (bins_x_r > NB_W'(MAX_BINS_X)) ? NB_W'(MAX_BINS_X) : bins_x_r;
    ny    = (bins_y_r > NB_W'(MAX_BINS_Y)) ? NB_W'(MAX_BINS_Y) : bins_y_r;
    empty = (nx == '0) || (ny == '0);

    // bin extent clipped at the core edge, never below zero
    xe  = lx_r + EDGE_W'(bin_w_r);
    xc  = (xe > EDGE_W'(core_right_r)) ? EDGE_W'(core_right_r) : xe;
    xr  = (xc < lx_r) ? lx_r : xc;
    wx  = SPAN_W'(xr - lx_r);
    ye  = ly_r + EDGE_W'(bin_h_r);
    yc  = (ye > EDGE_W'(core_top_r)) ? EDGE_W'(core_top_r) : ye;
    yr  = (yc < ly_r) ? ly_r : yc;
    wy  = SPAN_W'(yr - ly_r);

    xlo = (EDGE_W'(cmd_r.x0) > lx_r) ? EDGE_W'(cmd_r.x0) : lx_r;
    xhi = (EDGE_W'(cmd_r.x1) < xr) ? EDGE_W'(cmd_r.x1) : xr;
    spx = (xhi > xlo) ? SPAN_W'(xhi - xlo) : '0;
    ylo = (EDGE_W'(cmd_r.y0) > ly_r) ? EDGE_W'(cmd_r.y0) : ly_r;
    yhi = (EDGE_W'(cmd_r.y1) < yr) ? EDGE_W'(cmd_r.y1) : yr;
    spy = (yhi > ylo) ? SPAN_W'(yhi - ylo) : '0;

    last_bin = (i_r == xlast_r) && (j_r == ylast_r);
    uq       = {u_r, 16'd0};
    usum     = {1'b0, u_r} + 33'(prod_r);
    mat_sum  = {1'b0, mat_r} + (AREA_W+1)'(pop_data.area);

    pa = pcnt_r[1] ? 32'(sum_r[SUM_W-1:32]) : sum_r[31:0];
    pb = pcnt_r[0] ? k_r[K_W-1:KLO_W] : k_r[KLO_W-1:0];
    case (psel_r)
      2'd0:    pshift = P_W'(pp_r);
      2'd1:    pshift = P_W'(pp_r) << KLO_W;
      2'd2:    pshift = P_W'(pp_r) << 32;
      default: pshift = P_W'(pp_r) << (32 + KLO_W);
    endcase
  end

  assign out_load = (state_r == ST_OUT) && (!ores_v_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    pop_ready  = 1'b0;
    free_we    = 1'b0;
    use_we     = 1'b0;
    free_wdata = '0;
    use_wdata  = '0;
    div_req    = '0;
    unique case (state_r)
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          unique case (pop_data.kind)
            OP_CLEAR:   state_nxt = ST_BIN_RD;
            OP_FIXED:   state_nxt = empty ? ST_IDLE : ST_BIN_RD;
            OP_MOVABLE: state_nxt = (empty || pop_data.outside) ? ST_IDLE : ST_BIN_RD;
            OP_REPORT:  state_nxt = empty ? ST_FIN_MX : ST_BIN_RD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_BIN_RD:  state_nxt = ST_BIN_MUL;
      ST_BIN_MUL: state_nxt = ST_BIN_WR;
      ST_BIN_WR: begin
        case (cmd_r.kind)
          OP_CLEAR: begin
            free_we    = 1'b1;
            use_we     = 1'b1;
            free_wdata = (prod_r > PROD_W'(FREE_MAX)) ? FREE_MAX : prod_r[FREE_W-1:0];
          end
          OP_FIXED: begin
            free_we    = 1'b1;
            free_wdata = (PROD_W'(f_r) > prod_r) ? FREE_W'(PROD_W'(f_r) - prod_r) : '0;
          end
          OP_MOVABLE: begin
            use_we    = 1'b1;
            use_wdata = usum[32] ? '1 : usum[31:0];
          end
          default: ;
        endcase
        if (last_bin) state_nxt = (cmd_r.kind == OP_REPORT) ? ST_FIN_MX : ST_IDLE;
        else          state_nxt = ST_BIN_RD;
      end
      ST_FIN_MX: begin
        if (FREE_W'(ub_r[31:16]) >= fb_r) begin
          state_nxt = ST_FIN_RT;
        end else begin
          div_req.start = 1'b1;
          div_req.hi    = 64'(ub_r[31:16]);
          div_req.lo    = {ub_r[15:0], 16'd0};
          div_req.den   = 64'(fb_r);
          div_req.cnt   = DIV_Q32;
          state_nxt     = ST_MX_WAIT;
        end
      end
      ST_MX_WAIT: if (div_rsp.done) state_nxt = ST_FIN_RT;
      ST_FIN_RT: begin
        if (mat_r == '0 || AREA_W'(sum_r[SUM_W-1:32]) >= mat_r) begin
          state_nxt = ST_PEN_P;
        end else begin
          div_req.start = 1'b1;
          div_req.hi    = 64'(sum_r[SUM_W-1:32]);
          div_req.lo    = sum_r[31:0];
          div_req.den   = 64'(mat_r);
          div_req.cnt   = DIV_Q32;
          state_nxt     = ST_RT_WAIT;
        end
      end
      ST_RT_WAIT: if (div_rsp.done) state_nxt = ST_PEN_P;
      ST_PEN_P:   if (pcnt_r == 3'd4) state_nxt = ST_PEN_DIV;
      ST_PEN_DIV: begin
        if (pacc_r == '0 || mat_r == '0 ||
            pacc_r[P_W-1:S_W+16] >= (P_W-S_W-16)'(den_r)) begin
          state_nxt = ST_OUT;
        end else begin
          div_req.start = 1'b1;
          div_req.hi    = 64'(pacc_r[P_W-1:S_W+16]);
          div_req.lo    = {pacc_r[S_W+15:16], 8'd0};
          div_req.den   = 64'(den_r);
          div_req.cnt   = DIV_Q24;
          state_nxt     = ST_PEN_WAIT;
        end
      end
      ST_PEN_WAIT: if (div_rsp.done) state_nxt = ST_PEN_SQ;
      ST_PEN_SQ:   state_nxt = ST_OUT;
      ST_OUT:      if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= '0;
    end else if (state_r == ST_IDLE && pop_valid) begin
      if (pop_data.kind == OP_CLEAR) begin
        mat_r <= '0;
      end else if (pop_data.kind == OP_MOVABLE) begin
        mat_r <= mat_sum[AREA_W] ? '1 : mat_sum[AREA_W-1:0];
      end
    end
  end

  // operands that follow configuration and the running total
  always_ff @(posedge clk) begin
    bwh_r <= bin_w_r * bin_h_r;
    k_r   <= bwh_r * cmd_r.tu;
    den_r <= mat_r * DEN_W'(PEN_DIVISOR);
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          cmd_r   <= pop_data;
          i_r     <= '0;
          j_r     <= '0;
          lx_r    <= EDGE_W'(core_left_r);
          ly_r    <= EDGE_W'(core_bottom_r);
          xlast_r <= (pop_data.kind == OP_CLEAR) ? BX_W'(MAX_BINS_X - 1) : BX_W'(nx - 1'b1);
          ylast_r <= (pop_data.kind == OP_CLEAR) ? BY_W'(MAX_BINS_Y - 1) : BY_W'(ny - 1'b1);
          sum_r   <= '0;
          vio_r   <= '0;
          nz_r    <= '0;
          ub_r    <= '0;
          fb_r    <= FREE_W'(1);
        end
      end
      ST_BIN_RD: begin
        sx_r <= (cmd_r.kind == OP_CLEAR) ? wx : spx;
        sy_r <= (cmd_r.kind == OP_CLEAR) ? wy : spy;
      end
      ST_BIN_MUL: begin
        prod_r <= sx_r * sy_r;
        u_r    <= use_rdata;
        f_r    <= free_rdata;
        ft_r   <= free_rdata * cmd_r.tu;
        c1_r   <= use_rdata * fb_r;
        c2_r   <= ub_r * free_rdata;
      end
      ST_BIN_WR: begin
        if (cmd_r.kind == OP_REPORT) begin
          if (u_r != '0) nz_r <= nz_r + 1'b1;
          if (f_r != '0) begin
            if (uq > 48'(ft_r)) begin
              sum_r <= sum_r + SUM_W'(uq - 48'(ft_r));
              vio_r <= vio_r + 1'b1;
            end
            // keep the bin with the largest usage over free space
            if (c1_r > c2_r) begin
              ub_r <= u_r;
              fb_r <= f_r;
            end
          end
        end
        if (j_r == ylast_r) begin
          j_r  <= '0;
          ly_r <= EDGE_W'(core_bottom_r);
          i_r  <= i_r + 1'b1;
          lx_r <= lx_r + EDGE_W'(bin_w_r);
        end else begin
          j_r  <= j_r + 1'b1;
          ly_r <= ly_r + EDGE_W'(bin_h_r);
        end
      end
      ST_FIN_MX: begin
        pacc_r <= '0;
        pcnt_r <= '0;
        if (FREE_W'(ub_r[31:16]) >= fb_r) mx_r <= '1;
      end
      ST_MX_WAIT: if (div_rsp.done) mx_r <= div_rsp.quot;
      ST_FIN_RT: begin
        if (mat_r == '0) rt_r <= (sum_r != '0) ? '1 : '0;
        else if (AREA_W'(sum_r[SUM_W-1:32]) >= mat_r) rt_r <= '1;
      end
      ST_RT_WAIT: if (div_rsp.done) rt_r <= div_rsp.quot;
      ST_PEN_P: begin
        // partial products of overflow sum times bin area times target
        pp_r   <= pa * pb;
        psel_r <= pcnt_r[1:0];
        pcnt_r <= pcnt_r + 3'd1;
        if (pcnt_r != 3'd0) pacc_r <= pacc_r + pshift;
      end
      ST_PEN_DIV: begin
        if (pacc_r == '0) pen_r <= '0;
        else if (mat_r == '0) pen_r <= '1;
        else if (pacc_r[P_W-1:S_W+16] >= (P_W-S_W-16)'(den_r)) pen_r <= '1;
      end
      ST_PEN_WAIT: if (div_rsp.done) s_r <= div_rsp.quot[S_W-1:0];
      ST_PEN_SQ: pen_r <= 32'(({{S_W{1'b0}}, s_r} * {{S_W{1'b0}}, s_r}) >> 16);
      ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ores_v_r <= 1'b0;
    end else if (out_load) begin
      ores_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      ores_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_to_r  <= AREA_W'(sum_r[SUM_W-1:16]);
      o_vio_r <= vio_r;
      o_nz_r  <= nz_r;
      o_mx_r  <= mx_r;
      o_rt_r  <= rt_r;
      o_pen_r <= pen_r;
    end
  end

  assign out_ch.valid           = ores_v_r;
  assign out_ch.total_overflow  = o_to_r;
  assign out_ch.violation_count = o_vio_r;
  assign out_ch.nonzero_bins    = o_nz_r;
  assign out_ch.max_util        = o_mx_r;
  assign out_ch.overflow_ratio  = o_rt_r;
  assign out_ch.penalty         = o_pen_r;
endmodule

// ===== rtl/placement_bin_density_overflow_unit.sv =====
// channel  | direction | handshake         | carries
// in_ch    | in        | valid/ready       | opcode, rectangle, outside flag, target
// out_ch   | out       | valid/ready       | overflow, counts, peak, ratio, penalty
// cfg_*    | in        | write enable only | core region, bin size, bin counts
//
// a clear walks all 64x64 bins and a rectangle or report walks the configured bins,
// each bin in read, multiply and write states of the RMW loop on the bin memories.
// a report then runs the peak, ratio and penalty divisions (one bit per cycle in the
// shared divider) and sums partial products for the penalty before its division.
// reset restores the register defaults; bin memories hold garbage until a clear.
// a two-entry queue lets input beats keep arriving while the bin loop works or a
// result waits on out_ch.
module placement_bin_density_overflow_unit import pbdo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pbdo_in_if.sink               in_ch,
  pbdo_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  logic     push_valid, push_ready, pop_valid, pop_ready;
  cmd_t     push_data, pop_data;
  div_req_t div_req;
  div_rsp_t div_rsp;

  pbdo_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  pbdo_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  pbdo_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp)
  );

  pbdo_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
    .div_req(div_req), .div_rsp(div_rsp), .out_ch(out_ch)
  );
endmodule

// ===== verif/density_checker.sv =====
module density_checker import pbdo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pbdo_in_if                    in_ch,
  pbdo_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    reports_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [AREA_W-1:0] total_overflow;
    logic [CNT_W-1:0]  violation_count;
    logic [CNT_W-1:0]  nonzero_bins;
    logic [31:0]       max_util;
    logic [31:0]       overflow_ratio;
    logic [31:0]       penalty;
  } density_report_t;

  localparam u64_t USAGE_SAT = 64'hFFFF_FFFF;
  localparam u64_t AREA_SAT  = 64'hFFFF_FFFF_FFFF;
  localparam u64_t CNT_SAT   = 8191;

  logic [COORD_BITS-1:0] core_l, core_b, core_r, core_t;
  logic [BIN_W-1:0]      bin_w, bin_h;
  logic [NB_W-1:0]       cols, rows;

  logic [FREE_W-1:0] free_space [NBINS];
  logic [USE_W-1:0]  usage [NBINS];
  u64_t              movable_area;

  density_report_t expected_reports[$];

  assign reports_pending = expected_reports.size();

  // bin extent along one axis, clipped at the core edge
  function automatic void bin_bounds(input u64_t idx, input u64_t org, input u64_t sz,
                                     input u64_t lim, output u64_t lo, output u64_t hi);
    u64_t e;
    lo = org + idx * sz;
    e  = lo + sz;
    if (e > lim) e = lim;
    hi = (e < lo) ? lo : e;
  endfunction

  function automatic u64_t overlap(input u64_t a0, input u64_t a1, input u64_t b0,
                                   input u64_t b1);
    u64_t lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function automatic u64_t add_sat(input u64_t a, input u64_t b, input u64_t lim);
    u64_t s;
    s = a + b;
    if (s < a || s > lim) return lim;
    return s;
  endfunction

  function automatic void clear_grid();
    u64_t l, r, b, t, a;
    for (int i = 0; i < MAX_BINS_X; i++) begin
      bin_bounds(i, core_l, bin_w, core_r, l, r);
      for (int j = 0; j < MAX_BINS_Y; j++) begin
        bin_bounds(j, core_b, bin_h, core_t, b, t);
        a = (r - l) * (t - b);
        free_space[i*MAX_BINS_Y+j] = (a > u64_t'(FREE_MAX)) ? FREE_MAX : a[FREE_W-1:0];
        usage[i*MAX_BINS_Y+j] = '0;
      end
    end
    movable_area = 0;
  endfunction

  function automatic void place_rect(input bit fixed_cell, input u64_t x0, input u64_t y0,
                                     input u64_t w, input u64_t h, input bit outside);
    u64_t l, r, b, t, ov, nx, ny;
    int   k;
    if (!fixed_cell) begin
      movable_area = add_sat(movable_area, w * h, AREA_SAT);
      if (outside) return;
    end
    nx = (cols < MAX_BINS_X) ? cols : MAX_BINS_X;
    ny = (rows < MAX_BINS_Y) ? rows : MAX_BINS_Y;
    for (int i = 0; i < nx; i++) begin
      bin_bounds(i, core_l, bin_w, core_r, l, r);
      for (int j = 0; j < ny; j++) begin
        bin_bounds(j, core_b, bin_h, core_t, b, t);
        ov = overlap(x0, x0 + w, l, r) * overlap(y0, y0 + h, b, t);
        k = i * MAX_BINS_Y + j;
        if (fixed_cell)
          free_space[k] = (free_space[k] > ov) ? free_space[k] - ov[FREE_W-1:0] : '0;
        else
          usage[k] = USE_W'(add_sat(usage[k], ov, USAGE_SAT));
      end
    end
  endfunction

  function automatic density_report_t density_stats(input u64_t tu);
    density_report_t rep;
    u64_t nx, ny, u, f, sum, vio, nz, mx, ratio, pen, s, den;
    logic [127:0] prod, shifted;
    sum = 0; vio = 0; nz = 0; mx = 0;
    nx = (cols < MAX_BINS_X) ? cols : MAX_BINS_X;
    ny = (rows < MAX_BINS_Y) ? rows : MAX_BINS_Y;
    for (int i = 0; i < nx; i++) begin
      for (int j = 0; j < ny; j++) begin
        u = usage[i*MAX_BINS_Y+j];
        f = free_space[i*MAX_BINS_Y+j];
        if (u > 0 && nz < CNT_SAT) nz++;
        if (f != 0) begin
          if ((u << 16) > f * tu) begin
            sum = add_sat(sum, (u << 16) - f * tu, ~u64_t'(0));
            if (vio < CNT_SAT) vio++;
          end
          if ((u << 16) / f > mx) mx = (u << 16) / f;
        end
      end
    end
    if (mx > USAGE_SAT) mx = USAGE_SAT;
    if (movable_area == 0) ratio = (sum != 0) ? USAGE_SAT : 0;
    else begin
      ratio = sum / movable_area;
      if (ratio > USAGE_SAT) ratio = USAGE_SAT;
    end
    prod = 128'(sum) * 128'(u64_t'(bin_w) * u64_t'(bin_h) * tu);
    if (prod == 0) pen = 0;
    else if (movable_area == 0) pen = USAGE_SAT;
    else begin
      shifted = prod >> 16;
      den = movable_area * PEN_DIVISOR;
      if ((shifted >> 64) >= 128'(den)) s = ~u64_t'(0);
      else s = 64'(shifted / 128'(den));
      if (s >= (u64_t'(1) << 24)) pen = USAGE_SAT;
      else begin
        pen = (s * s) >> 16;
        if (pen > USAGE_SAT) pen = USAGE_SAT;
      end
    end
    rep.total_overflow  = sum[63:16];
    rep.violation_count = vio[CNT_W-1:0];
    rep.nonzero_bins    = nz[CNT_W-1:0];
    rep.max_util        = mx[31:0];
    rep.overflow_ratio  = ratio[31:0];
    rep.penalty         = pen[31:0];
    return rep;
  endfunction

  task automatic mismatch(input string field, input u64_t want, input u64_t got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    density_report_t want, got;
    if (!rst_n) begin
      core_l <= '0; core_b <= '0; core_r <= 20'd4096; core_t <= 20'd4096;
      bin_w <= 13'd64; bin_h <= 13'd64; cols <= 7'd64; rows <= 7'd64;
      movable_area = 0;
      fail_count = 0;
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_CORE_LEFT:   core_l <= cfg_wdata;
          CFG_CORE_BOTTOM: core_b <= cfg_wdata;
          CFG_CORE_RIGHT:  core_r <= cfg_wdata;
          CFG_CORE_TOP:    core_t <= cfg_wdata;
          CFG_BIN_WIDTH:   bin_w  <= cfg_wdata[BIN_W-1:0];
          CFG_BIN_HEIGHT:  bin_h  <= cfg_wdata[BIN_W-1:0];
          CFG_BINS_X:      cols   <= cfg_wdata[NB_W-1:0];
          CFG_BINS_Y:      rows   <= cfg_wdata[NB_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.total_overflow, out_ch.violation_count, out_ch.nonzero_bins,
                out_ch.max_util, out_ch.overflow_ratio, out_ch.penalty};
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result beat, actual %p", $time, got);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (want.total_overflow != got.total_overflow)
            mismatch("total_overflow", want.total_overflow, got.total_overflow);
          if (want.violation_count != got.violation_count)
            mismatch("violation_count", want.violation_count, got.violation_count);
          if (want.nonzero_bins != got.nonzero_bins)
            mismatch("nonzero_bins", want.nonzero_bins, got.nonzero_bins);
          if (want.max_util != got.max_util)
            mismatch("max_util", want.max_util, got.max_util);
          if (want.overflow_ratio != got.overflow_ratio)
            mismatch("overflow_ratio", want.overflow_ratio, got.overflow_ratio);
          if (want.penalty != got.penalty)
            mismatch("penalty", want.penalty, got.penalty);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (op_t'(in_ch.opcode))
          OP_CLEAR:   clear_grid();
          OP_FIXED:   place_rect(1'b1, in_ch.pos_x, in_ch.pos_y, in_ch.size_w,
                                 in_ch.size_h, 1'b0);
          OP_MOVABLE: place_rect(1'b0, in_ch.pos_x, in_ch.pos_y, in_ch.size_w,
                                 in_ch.size_h, in_ch.outside_core);
          default:    expected_reports.push_back(density_stats(in_ch.target_util));
        endcase
      end
    end
  end
endmodule

// ===== verif/placement_bin_density_overflow_unit_tb.sv =====
module placement_bin_density_overflow_unit_tb;
  import pbdo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 200000;
  localparam int N_PHASES    = 9;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    reports_pending;
  bit                    idle_on;
  int                    long_hold;

  logic [19:0] grid_l, grid_b;
  int          grid_bw, grid_bh, grid_nx, grid_ny;

  pbdo_in_if  in_ch();
  pbdo_out_if out_ch();

  placement_bin_density_overflow_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  density_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .reports_pending(reports_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (long_hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic cfg_write(input cfg_idx_t idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_grid(input int unsigned l, b, r, t, bw, bh, nx, ny);
    cfg_write(CFG_CORE_LEFT, l);
    cfg_write(CFG_CORE_BOTTOM, b);
    cfg_write(CFG_CORE_RIGHT, r);
    cfg_write(CFG_CORE_TOP, t);
    cfg_write(CFG_BIN_WIDTH, bw);
    cfg_write(CFG_BIN_HEIGHT, bh);
    cfg_write(CFG_BINS_X, nx);
    cfg_write(CFG_BINS_Y, ny);
    cfg_we <= 1'b0;
    @(posedge clk);
    grid_l = l[19:0]; grid_b = b[19:0];
    grid_bw = bw; grid_bh = bh; grid_nx = nx; grid_ny = ny;
  endtask

  task automatic send(input op_t op, input logic [19:0] x, y, w, h,
                      input logic oc, input logic [TU_W-1:0] tu);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.pos_x        <= x;
    in_ch.pos_y        <= y;
    in_ch.size_w       <= w;
    in_ch.size_h       <= h;
    in_ch.outside_core <= oc;
    in_ch.target_util  <= tu;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // end each phase on a report so the block is idle once its beat is back
  task automatic drain();
    send(OP_REPORT, '0, '0, '0, '0, 1'b0, 18'd65536);
    in_ch.valid <= 1'b0;
    // let the checker log the last report before looking at the count
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [TU_W-1:0] rand_target();
    return TU_W'($urandom_range(0, 131072));
  endfunction

  task automatic random_item(input bit huge_cells);
    int unsigned sel, span_x, span_y;
    logic [19:0] x, y, w, h;
    sel    = $urandom_range(0, 99);
    span_x = grid_nx * grid_bw + grid_bw;
    span_y = grid_ny * grid_bh + grid_bh;
    if ($urandom_range(0, 9) == 0) begin
      x = 20'($urandom); y = 20'($urandom); w = 20'($urandom); h = 20'($urandom);
    end else begin
      x = 20'(grid_l + $urandom_range(0, span_x));
      y = 20'(grid_b + $urandom_range(0, span_y));
      w = ($urandom_range(0, 4) == 0) ? 20'($urandom_range(0, span_x))
                                      : 20'($urandom_range(0, 2 * grid_bw));
      h = ($urandom_range(0, 4) == 0) ? 20'($urandom_range(0, span_y))
                                      : 20'($urandom_range(0, 2 * grid_bh));
    end
    if (huge_cells && sel < 80)
      send(OP_MOVABLE, '0, '0, 20'hFFFFF, 20'hFFFFF, 1'($urandom_range(0, 1)), '0);
    else if (sel < 1)
      send(OP_CLEAR, x, y, w, h, 1'b0, '0);
    else if (sel < 26)
      send(OP_FIXED, x, y, w, h, 1'b0, '0);
    else if (sel < 70)
      send(OP_MOVABLE, x, y, w, h, $urandom_range(0, 5) == 0, '0);
    else
      send(OP_REPORT, x, y, w, h, 1'b0, rand_target());
  endtask

  task automatic random_phase(input int unsigned l, b, r, t, bw, bh, nx, ny,
                              input int n_items, input bit huge_cells);
    set_grid(l, b, r, t, bw, bh, nx, ny);
    send(OP_CLEAR, '0, '0, '0, '0, 1'b0, '0);
    repeat (n_items) random_item(huge_cells);
    drain();
  endtask

  initial begin
    int unsigned rl, rb, rbw, rbh, rnx, rny;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    idle_on      = 1'b1;
    long_hold    = 0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_CLEAR;
    in_ch.pos_x  = '0;
    in_ch.pos_y  = '0;
    in_ch.size_w = '0;
    in_ch.size_h = '0;
    in_ch.outside_core = 1'b0;
    in_ch.target_util  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bins clipped at the right and top core edges, some with no area
    set_grid(1000, 2000, 1350, 2120, 100, 50, 8, 8);
    send(OP_CLEAR, '0, '0, '0, '0, 1'b0, '0);
    send(OP_REPORT, '0, '0, '0, '0, 1'b0, 18'd65536);
    send(OP_FIXED, 20'd1000, 20'd2000, 20'd100, 20'd50, 1'b0, '0);
    send(OP_FIXED, 20'd1000, 20'd2000, 20'd150, 20'd60, 1'b0, '0);
    send(OP_FIXED, 20'd1000, 20'd2000, 20'd150, 20'd60, 1'b0, '0);
    send(OP_MOVABLE, 20'd1000, 20'd2000, 20'd100, 20'd50, 1'b0, '0);
    send(OP_MOVABLE, 20'd1080, 20'd2030, 20'd200, 20'd70, 1'b0, '0);
    send(OP_MOVABLE, 20'd1100, 20'd2000, 20'd50, 20'd50, 1'b1, '0);
    send(OP_MOVABLE, 20'd1200, 20'd2010, 20'd0, 20'd30, 1'b0, '0);
    send(OP_FIXED, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b0, '0);
    send(OP_MOVABLE, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b0, '0);
    send(OP_MOVABLE, '0, '0, 20'hFFFFF, 20'hFFFFF, 1'b0, '0);
    send(OP_REPORT, '0, '0, '0, '0, 1'b0, 18'd0);
    send(OP_REPORT, '0, '0, '0, '0, 1'b0, 18'd131072);
    send(OP_REPORT, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b1, 18'd1);
    send(OP_CLEAR, '0, '0, '0, '0, 1'b0, '0);
    send(OP_REPORT, '0, '0, '0, '0, 1'b0, 18'd65536);
    drain();

    // long result hold-off while items keep coming
    long_hold = 3000;
    random_phase(0, 0, 4096, 4096, 512, 512, 8, 8, 250, 1'b0);
    random_phase(5, 7, 300, 200, 37, 23, 8, 8, 250, 1'b0);
    // full grid, slow per item
    random_phase(0, 0, 4096, 4096, 64, 64, 64, 64, 6, 1'b0);
    // usage and total area saturation
    random_phase(0, 0, 20'hFFFFF, 20'hFFFFF, 4096, 4096, 2, 2, 300, 1'b1);
    // empty core
    random_phase(20'hFFFFF, 20'hFFFFF, 0, 0, 1, 1, 64, 1, 60, 1'b0);
    random_phase(0, 0, 64, 20'hFFFFF, 1, 4096, 64, 2, 200, 1'b0);
    rnx = $urandom_range(1, 6); rny = $urandom_range(1, 6);
    rbw = $urandom_range(1, 4096); rbh = $urandom_range(1, 4096);
    rl  = $urandom_range(0, 2000); rb = $urandom_range(0, 2000);
    random_phase(rl, rb, rl + $urandom_range(0, rnx * rbw + rbw),
                 rb + $urandom_range(0, rny * rbh + rbh), rbw, rbh, rnx, rny, 300, 1'b0);
    idle_on = 1'b0;
    random_phase(100, 100, 1000, 900, 128, 100, 6, 6, 300, 1'b0);

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
